// ===== hdl/svdbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package svdbs_pkg;

  localparam int DATA_W = 32;
  localparam int ACC_W  = 64;
  localparam int DIM_W  = 5;

  typedef enum logic [2:0] {
    OP_LOAD_U = 3'd0,
    OP_LOAD_W = 3'd1,
    OP_LOAD_V = 3'd2,
    OP_LOAD_B = 3'd3,
    OP_SOLVE  = 3'd4
  } svdbs_op_e;

  typedef enum logic {
    CFG_ROWS_USED = 1'b0,
    CFG_COLS_USED = 1'b1
  } svdbs_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_W_RD,
    ST_W_CHK,
    ST_T_MAC,
    ST_T_DIV,
    ST_X_MAC,
    ST_X_OUT
  } svdbs_state_e;

  typedef struct packed {
    logic clr;
    logic vld;
  } mac_ctrl_t;

  typedef struct packed {
    logic                     done;
    logic                     sat;
    logic signed [DATA_W-1:0] q;
  } div_res_t;

endpackage

`default_nettype wire

// ===== hdl/svdbs_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none

module svdbs_mac import svdbs_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire mac_ctrl_t                ctrl_i,
  input  wire logic signed [DATA_W-1:0] a_i,
  input  wire logic signed [DATA_W-1:0] b_i,
  output logic                          busy_o,
  output logic signed [ACC_W-1:0]       acc_o
);

  logic signed [ACC_W-1:0] prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic                    pv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= ctrl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ACC_W'(a_i) * ACC_W'(b_i);
    if (ctrl_i.clr) begin
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= acc_q + (prod_q >>> 8);
    end
  end

  assign busy_o = pv_q;
  assign acc_o  = acc_q;

endmodule

`default_nettype wire

// ===== hdl/svdbs_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module svdbs_div import svdbs_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic signed [ACC_W-1:0]  num_i,
  input  wire logic signed [DATA_W-1:0] den_i,
  output div_res_t                      res_o
);

  logic              busy_q, fin_q, done_q;
  logic [4:0]        cnt_q;
  logic [31:0]       r_q, dl_q, ud_q, qm_q;
  logic              neg_q, sat_q;
  logic [31:0]       res_q;

  logic [ACC_W-1:0]  un;
  logic [31:0]       ud;
  logic              neg, ovf;
  logic [32:0]       rs;
  logic              ge;
  logic [31:0]       limit, mag;

  always_comb begin
    neg   = num_i[ACC_W-1] ^ den_i[DATA_W-1];
    un    = num_i[ACC_W-1] ? ACC_W'(-num_i) : ACC_W'(num_i);
    ud    = den_i[DATA_W-1] ? 32'(-den_i) : 32'(den_i);
    ovf   = un[63:24] >= {8'd0, ud};
    rs    = {r_q, dl_q[31]};
    ge    = rs >= {1'b0, ud_q};
    limit = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
    mag   = (qm_q > limit) ? limit : qm_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      fin_q  <= 1'b0;
      if (start_i) begin
        cnt_q <= '0;
        if (ovf) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
      if (fin_q) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= neg;
      ud_q  <= ud;
      r_q   <= un[55:24];
      dl_q  <= {un[23:0], 8'd0};
      qm_q  <= '0;
      if (ovf) begin
        res_q <= neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        sat_q <= 1'b1;
      end
    end else if (busy_q) begin
      r_q  <= ge ? 32'(rs - {1'b0, ud_q}) : rs[31:0];
      dl_q <= {dl_q[30:0], 1'b0};
      qm_q <= {qm_q[30:0], ge};
    end else if (fin_q) begin
      res_q <= neg_q ? 32'(-mag) : mag;
      sat_q <= qm_q > limit;
    end
  end

  assign res_o.done = done_q;
  assign res_o.sat  = sat_q;
  assign res_o.q    = res_q;

endmodule

`default_nettype wire

// ===== hdl/svd_backsubstitution_solve_unit.sv =====
// SVD back-substitution solver, signed Q8.24 throughout.
// Input stream (s_axis_*): tuser carries the operation, tdata the row and
// column indexes and the value. Load transactions write U, W, V or b and
// produce nothing. A solve transaction computes t[j] = (U column j . b) /
// W[j] and then x[i] = V row i . t, emitting one output transaction per
// column; tlast marks the final one, tuser flags saturation of x[i] or of
// any t[j] of that solve.
// A solve uses one shared multiply-accumulate unit, then a 32-step
// shift-subtract divider, for each column with nonzero W; a zero W gives
// t[j] = 0 without a division. Each output then goes through the same
// multiply-accumulate unit. The input is not ready while a solve runs;
// loads sustain one per cycle.
// The output register holds a result until taken; a stalled receiver holds
// the solve, not the earlier results.
// Configuration (cfg_*): index 0 rows_used, 1 cols_used, both reset to 16, to
// be written while idle; 0 acts as 1, values above the maximum as the maximum.
// Reset clears control state; the stores hold garbage until loaded.
`timescale 1ns / 1ps
`default_nettype none

module svd_backsubstitution_solve_unit import svdbs_pkg::*; #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [39:0]      s_axis_tdata,   // row_index, col_index, value
  input  wire logic [2:0]       s_axis_tuser,   // operation
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [39:0]           m_axis_tdata,   // solution_index, solution_value
  output logic                  m_axis_tuser,   // saturated
  output logic                  m_axis_tlast,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic             cfg_index_i,
  input  wire logic [DIM_W-1:0] cfg_data_i
);

  localparam int MAXD = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int RAW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CAW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int UAW  = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1;
  localparam int VAW  = (MAX_COLS * MAX_COLS > 1) ? $clog2(MAX_COLS * MAX_COLS) : 1;
  localparam int RCW  = $clog2(MAX_ROWS + 1);
  localparam int CCW  = $clog2(MAX_COLS + 1);
  localparam int KW   = $clog2(MAXD + 1);

  logic [DATA_W-1:0] u_mem [MAX_ROWS*MAX_COLS];
  logic [DATA_W-1:0] v_mem [MAX_COLS*MAX_COLS];
  logic [DATA_W-1:0] w_mem [MAX_COLS];
  logic [DATA_W-1:0] b_mem [MAX_ROWS];
  logic [DATA_W-1:0] t_mem [MAX_COLS];

  svdbs_state_e state_q, state_d;
  logic [DIM_W-1:0] rows_used_q, cols_used_q;
  logic [RCW-1:0]   rows_q, rows_d, eff_rows;
  logic [CCW-1:0]   cols_q, cols_d, eff_cols;
  logic [CCW-1:0]   o_q, o_d;
  logic [KW-1:0]    k_q, k_d, n_mac;
  logic             tsat_q, tsat_d;
  logic             p1_q;

  logic [DATA_W-1:0] u_rd_q, v_rd_q, b_rd_q, t_rd_q, w_rd_q;
  logic              rd_en, w_rd_en, t_we, col_next, mac_clr, div_start, out_load, last_col;
  logic [DATA_W-1:0] t_wdata;

  logic              in_fire;
  svdbs_op_e         op;
  logic [3:0]        in_row, in_col;
  logic [DATA_W-1:0] in_val;
  logic              row_ok, col_ok;
  logic [UAW-1:0]    u_waddr, u_raddr;
  logic [VAW-1:0]    v_waddr, v_raddr;

  mac_ctrl_t               mac_ctrl;
  logic                    mac_busy;
  logic signed [ACC_W-1:0] acc;
  logic                    x_phase;
  div_res_t                div_res;

  logic              out_v_q, out_sat_q, out_last_q;
  logic [3:0]        out_idx_q;
  logic [DATA_W-1:0] out_val_q, x_val;
  logic              x_ovf;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign op      = svdbs_op_e'(s_axis_tuser);
  assign in_row  = s_axis_tdata[3:0];
  assign in_col  = s_axis_tdata[7:4];
  assign in_val  = s_axis_tdata[39:8];
  assign row_ok  = 32'(in_row) < MAX_ROWS;
  assign col_ok  = 32'(in_col) < MAX_COLS;
  assign u_waddr = UAW'(32'(in_row) * MAX_COLS + 32'(in_col));
  assign v_waddr = VAW'(32'(in_row) * MAX_COLS + 32'(in_col));
  assign u_raddr = UAW'(32'(k_q) * MAX_COLS + 32'(o_q));
  assign v_raddr = VAW'(32'(o_q) * MAX_COLS + 32'(k_q));

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_used_q <= DIM_W'(16);
      cols_used_q <= DIM_W'(16);
    end else if (cfg_valid_i) begin
      unique case (svdbs_cfg_e'(cfg_index_i))
        CFG_ROWS_USED: rows_used_q <= cfg_data_i;
        CFG_COLS_USED: cols_used_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (rows_used_q == '0) begin
      eff_rows = RCW'(1);
    end else if (32'(rows_used_q) > MAX_ROWS) begin
      eff_rows = RCW'(MAX_ROWS);
    end else begin
      eff_rows = RCW'(rows_used_q);
    end
    if (cols_used_q == '0) begin
      eff_cols = CCW'(1);
    end else if (32'(cols_used_q) > MAX_COLS) begin
      eff_cols = CCW'(MAX_COLS);
    end else begin
      eff_cols = CCW'(cols_used_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && op == OP_LOAD_U && row_ok && col_ok) begin
      u_mem[u_waddr] <= in_val;
    end
    if (in_fire && op == OP_LOAD_V && row_ok && col_ok) begin
      v_mem[v_waddr] <= in_val;
    end
    if (in_fire && op == OP_LOAD_W && 32'(in_row) < MAX_COLS) begin
      w_mem[in_row[CAW-1:0]] <= in_val;
    end
    if (in_fire && op == OP_LOAD_B && row_ok) begin
      b_mem[in_row[RAW-1:0]] <= in_val;
    end
    if (t_we) begin
      t_mem[o_q[CAW-1:0]] <= t_wdata;
    end
    if (w_rd_en) begin
      w_rd_q <= w_mem[o_q[CAW-1:0]];
    end
    if (rd_en) begin
      u_rd_q <= u_mem[u_raddr];
      v_rd_q <= v_mem[v_raddr];
      b_rd_q <= b_mem[k_q[RAW-1:0]];
      t_rd_q <= t_mem[k_q[CAW-1:0]];
    end
  end

  assign last_col = (o_q == CCW'(cols_q - 1'b1));
  assign n_mac    = (state_q == ST_T_MAC) ? KW'(rows_q) : KW'(cols_q);

  always_comb begin
    state_d   = state_q;
    rows_d    = rows_q;
    cols_d    = cols_q;
    o_d       = o_q;
    k_d       = k_q;
    tsat_d    = tsat_q;
    rd_en     = 1'b0;
    w_rd_en   = 1'b0;
    t_we      = 1'b0;
    t_wdata   = '0;
    col_next  = 1'b0;
    mac_clr   = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && op == OP_SOLVE) begin
          rows_d  = eff_rows;
          cols_d  = eff_cols;
          o_d     = '0;
          tsat_d  = 1'b0;
          state_d = ST_W_RD;
        end
      end
      ST_W_RD: begin
        w_rd_en = 1'b1;
        state_d = ST_W_CHK;
      end
      ST_W_CHK: begin
        if (w_rd_q == '0) begin
          t_we     = 1'b1;
          col_next = 1'b1;
        end else begin
          mac_clr = 1'b1;
          k_d     = '0;
          state_d = ST_T_MAC;
        end
      end
      ST_T_MAC, ST_X_MAC: begin
        if (k_q < n_mac) begin
          rd_en = 1'b1;
          k_d   = k_q + 1'b1;
        end else if (!p1_q && !mac_busy) begin
          if (state_q == ST_T_MAC) begin
            div_start = 1'b1;
            state_d   = ST_T_DIV;
          end else begin
            state_d = ST_X_OUT;
          end
        end
      end
      ST_T_DIV: begin
        if (div_res.done) begin
          t_we     = 1'b1;
          t_wdata  = div_res.q;
          tsat_d   = tsat_q | div_res.sat;
          col_next = 1'b1;
        end
      end
      ST_X_OUT: begin
        if (!out_v_q || m_axis_tready) begin
          out_load = 1'b1;
          mac_clr  = 1'b1;
          if (last_col) begin
            state_d = ST_IDLE;
          end else begin
            o_d     = o_q + 1'b1;
            k_d     = '0;
            state_d = ST_X_MAC;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (col_next) begin
      if (last_col) begin
        o_d     = '0;
        k_d     = '0;
        mac_clr = 1'b1;
        state_d = ST_X_MAC;
      end else begin
        o_d     = o_q + 1'b1;
        state_d = ST_W_RD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rows_q  <= RCW'(1);
      cols_q  <= CCW'(1);
      o_q     <= '0;
      k_q     <= '0;
      tsat_q  <= 1'b0;
      p1_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rows_q  <= rows_d;
      cols_q  <= cols_d;
      o_q     <= o_d;
      k_q     <= k_d;
      tsat_q  <= tsat_d;
      p1_q    <= rd_en;
    end
  end

  assign x_phase      = (state_q == ST_X_MAC);
  assign mac_ctrl.clr = mac_clr;
  assign mac_ctrl.vld = p1_q;

  svdbs_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (x_phase ? v_rd_q : u_rd_q),
    .b_i    (x_phase ? t_rd_q : b_rd_q),
    .busy_o (mac_busy),
    .acc_o  (acc)
  );

  svdbs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (acc),
    .den_i   (w_rd_q),
    .res_o   (div_res)
  );

  assign x_ovf = (acc[63:47] != {17{acc[63]}});
  assign x_val = x_ovf ? (acc[63] ? 32'h8000_0000 : 32'h7FFF_FFFF) : acc[47:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_idx_q  <= 4'(o_q);
      out_val_q  <= x_val;
      out_sat_q  <= tsat_q | x_ovf;
      out_last_q <= last_col;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {4'd0, out_val_q, out_idx_q};
  assign m_axis_tuser  = out_sat_q;
  assign m_axis_tlast  = out_last_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == ST_IDLE)
    else $error("input ready outside idle");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> state_q == ST_T_DIV)
    else $error("divider finished outside divide state");

  a_mac_busy_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_busy |-> (state_q == ST_T_MAC || state_q == ST_X_MAC))
    else $error("product in flight outside accumulate states");

  a_dims_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> (rows_q != '0 && cols_q != '0))
    else $error("solve running with zero dimension");

endmodule

`default_nettype wire
